@@ rtl/core/msp_pkg.sv @@
// msp_pkg: shared widths, constants and state encoding for the moving-sum
// percent-change block. No dependencies; imported by every module of the block.
package msp_pkg;

    localparam int unsigned DEF_MAX_WINDOW  = 256;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    localparam int unsigned SUM_BITS     = 24;
    localparam int unsigned PCT_BITS     = 32;
    localparam int unsigned WIN_CFG_BITS = 9;
    localparam logic [WIN_CFG_BITS-1:0] WIN_RESET = WIN_CFG_BITS'(7);

    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned PCT_SCALE  = 100;
    localparam int unsigned SCALE_Q8   = PCT_SCALE << FRAC_BITS;
    localparam int unsigned SCALE_BITS = $clog2(SCALE_Q8 + 1);

    // |diff| * scale, quotient magnitude
    localparam int unsigned NUM_BITS = SUM_BITS + SCALE_BITS;
    localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

    localparam logic [PCT_BITS-1:0] PCT_MAX = {1'b0, {(PCT_BITS-1){1'b1}}};
    localparam logic [PCT_BITS-1:0] PCT_MIN = {1'b1, {(PCT_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_EMIT
    } msp_state_t;

endpackage

@@ rtl/core/msp_div.sv @@
// msp_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on msp_pkg (NUM_BITS, SUM_BITS, CNT_BITS).
module msp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [msp_pkg::NUM_BITS-1:0]  numer,
    input  logic [msp_pkg::SUM_BITS-1:0]  denom,
    output logic                          done,
    output logic [msp_pkg::NUM_BITS-1:0]  quotient
);
    import msp_pkg::*;

    logic [NUM_BITS-1:0] quo_reg;
    logic [SUM_BITS-1:0] rem_reg;
    logic [SUM_BITS-1:0] den_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [SUM_BITS:0]   shifted;
    logic [SUM_BITS:0]   trial;
    logic                q_bit;

    always_comb begin
        shifted = {rem_reg, quo_reg[NUM_BITS-1]};
        trial   = shifted - {1'b0, den_reg};
        q_bit   = (shifted >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], q_bit};
            rem_reg <= q_bit ? trial[SUM_BITS-1:0] : shifted[SUM_BITS-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/moving_sum_percent_change.sv @@
// moving_sum_percent_change: sliding-window sum with Q.8 percent change.
// Depends on msp_pkg and msp_div.
//
//  channel | ports                                       | word
//  --------+---------------------------------------------+---------------------------
//  in      | s_valid / s_ready                           | s_sample
//  out     | m_valid / m_ready                           | m_moving_sum, m_percent_q8,
//          |                                             | m_percent_infinite
//  config  | cfg_wr_en                                   | cfg_wr_data (window length)
//
// A word passes through accept, sum update, scale multiply, divider start,
// the 39-step bit-serial divider (ending with its done flag) and the emit
// state. A word with zero previous sum skips the divider. The next word is
// accepted while a result waits in the output register; that word then holds
// in its emit state until m_ready. Synchronous active-low reset; the delay
// line needs no clearing, as an entry's value is used only after it is written.
module moving_sum_percent_change #(
    parameter int unsigned MAX_WINDOW  = msp_pkg::DEF_MAX_WINDOW,
    parameter int unsigned SAMPLE_BITS = msp_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [msp_pkg::WIN_CFG_BITS-1:0]    cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [SAMPLE_BITS-1:0]              s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [msp_pkg::SUM_BITS-1:0]        m_moving_sum,
    output logic signed [msp_pkg::PCT_BITS-1:0] m_percent_q8,
    output logic                                m_percent_infinite
);
    import msp_pkg::*;

    localparam int unsigned PTR_BITS = $clog2(MAX_WINDOW);
    localparam int unsigned WIN_BITS = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CMP_BITS = (WIN_BITS > WIN_CFG_BITS) ? WIN_BITS : WIN_CFG_BITS;

    msp_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0]  mem [MAX_WINDOW];
    logic [WIN_CFG_BITS-1:0] win_cfg_reg;
    logic [PTR_BITS-1:0]     wp_reg;
    logic [WIN_BITS-1:0]     seen_reg;
    logic [SUM_BITS-1:0]     prev_sum_reg;

    logic [SAMPLE_BITS-1:0]  x_reg;
    logic [SAMPLE_BITS-1:0]  rd_reg;
    logic                    leave_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [NUM_BITS-1:0]     prod_reg;
    logic                    neg_reg;

    logic                    m_valid_reg;
    logic [SUM_BITS-1:0]     m_sum_reg;
    logic [PCT_BITS-1:0]     m_pct_reg;
    logic                    m_inf_reg;

    logic [CMP_BITS-1:0]     cfg_ext;
    logic [WIN_BITS-1:0]     w_eff;
    logic [WIN_BITS:0]       wp_ext;
    logic [WIN_BITS:0]       rd_sum;
    logic [PTR_BITS-1:0]     rd_addr;

    logic [SUM_BITS-1:0]     sum_calc;
    logic [SUM_BITS:0]       diff;
    logic [SUM_BITS-1:0]     mag;

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    div_start;
    logic                    div_done;
    logic [NUM_BITS-1:0]     div_q;
    logic [PCT_BITS-1:0]     pct_calc;
    logic                    inf_calc;

    // effective window and leaving-sample address
    always_comb begin
        cfg_ext = CMP_BITS'(win_cfg_reg);
        if (cfg_ext == '0) begin
            w_eff = WIN_BITS'(1);
        end else if (cfg_ext > CMP_BITS'(MAX_WINDOW)) begin
            w_eff = WIN_BITS'(MAX_WINDOW);
        end else begin
            w_eff = WIN_BITS'(cfg_ext);
        end
        wp_ext = (WIN_BITS + 1)'(wp_reg);
        if (wp_ext >= (WIN_BITS + 1)'(w_eff)) begin
            rd_sum = wp_ext - (WIN_BITS + 1)'(w_eff);
        end else begin
            rd_sum = wp_ext + (WIN_BITS + 1)'(MAX_WINDOW) - (WIN_BITS + 1)'(w_eff);
        end
        rd_addr = rd_sum[PTR_BITS-1:0];
    end

    always_comb begin
        sum_calc = prev_sum_reg + SUM_BITS'(x_reg)
                 - (leave_reg ? SUM_BITS'(rd_reg) : SUM_BITS'(0));
        diff     = {1'b0, sum_reg} - {1'b0, prev_sum_reg};
        mag      = diff[SUM_BITS] ? SUM_BITS'(-diff) : diff[SUM_BITS-1:0];
    end

    always_comb begin
        inf_calc = (prev_sum_reg == '0);
        if (inf_calc) begin
            pct_calc = PCT_MAX;
        end else if (!neg_reg) begin
            pct_calc = (|div_q[NUM_BITS-1:PCT_BITS-1]) ? PCT_MAX : div_q[PCT_BITS-1:0];
        end else begin
            pct_calc = (|div_q[NUM_BITS-1:PCT_BITS-1]) ? PCT_MIN : -div_q[PCT_BITS-1:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = inf_calc ? ST_EMIT : ST_START;
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg <= WIN_RESET;
        end else if (cfg_wr_en) begin
            win_cfg_reg <= cfg_wr_data;
        end
    end

    // delay line, registered read, read-first
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= mem[rd_addr];
        end
        if (state_reg == ST_SUM) begin
            mem[wp_reg] <= x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            seen_reg     <= '0;
            prev_sum_reg <= '0;
        end else begin
            if (state_reg == ST_SUM) begin
                wp_reg <= (wp_reg == PTR_BITS'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (seen_reg != WIN_BITS'(MAX_WINDOW)) begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
            if (load_out) begin
                prev_sum_reg <= sum_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg     <= s_sample;
            leave_reg <= (seen_reg >= w_eff);
        end
        if (state_reg == ST_SUM) begin
            sum_reg <= sum_calc;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= NUM_BITS'(mag) * NUM_BITS'(SCALE_Q8);
            neg_reg  <= diff[SUM_BITS];
        end
    end

    msp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (prod_reg),
        .denom    (prev_sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_sum_reg <= sum_reg;
            m_pct_reg <= pct_calc;
            m_inf_reg <= inf_calc;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_moving_sum       = m_sum_reg;
    assign m_percent_q8       = m_pct_reg;
    assign m_percent_infinite = m_inf_reg;

endmodule

@@ rtl/core/msp_checker.sv @@
// msp_checker: port-level checks for moving_sum_percent_change, bound to it.
// Depends on msp_pkg.
module msp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [msp_pkg::SUM_BITS-1:0]        m_moving_sum,
    input logic signed [msp_pkg::PCT_BITS-1:0] m_percent_q8,
    input logic                                m_percent_infinite
);
    import msp_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_moving_sum)
            && $stable(m_percent_q8) && $stable(m_percent_infinite))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready ##1 !s_ready)
        else $error("input accepted while a word is in work");

    a_inf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_percent_infinite |-> m_percent_q8 == $signed(PCT_MAX))
        else $error("infinite flag without saturated percent");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind moving_sum_percent_change msp_checker u_msp_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_moving_sum       (m_moving_sum),
    .m_percent_q8       (m_percent_q8),
    .m_percent_infinite (m_percent_infinite)
);

@@ tb/moving_sum_percent_change_tb.sv @@
// Self-checking testbench for moving_sum_percent_change: random and directed sample words,
// a window-sum / Q.8 percent predictor in a scoreboard class, random stalls on both channels.
// Depends on msp_pkg and the moving_sum_percent_change RTL.
module moving_sum_percent_change_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    localparam int unsigned SAMPLE_W    = DEF_SAMPLE_BITS;
    localparam int unsigned WINDOW_MAX  = DEF_MAX_WINDOW;
    localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE      = 60;

    typedef enum {SRC_MIXED, SRC_PEAK_FIRST} sample_src_t;

    typedef struct {
        logic [SUM_BITS-1:0] moving_sum;
        logic [PCT_BITS-1:0] percent;
        logic                infinite;
    } pct_word_t;

    class window_sum_board;
        logic [SAMPLE_W-1:0] history [WINDOW_MAX];
        int unsigned         head;
        int unsigned         filled;
        int unsigned         window;
        logic [SUM_BITS-1:0] last_sum;
        pct_word_t           awaited_figures[$];
        int unsigned         errors;

        function new();
            head     = 0;
            filled   = 0;
            window   = WIN_RESET;
            last_sum = '0;
            errors   = 0;
        endfunction

        function void set_window(int unsigned w);
            window = w;
        endfunction

        function int unsigned pending();
            return awaited_figures.size();
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // one accepted sample word -> expected sum and percent figure
        function void advance_window(logic [SAMPLE_W-1:0] x);
            int unsigned         span;
            logic [SAMPLE_W-1:0] leaving;
            logic [SUM_BITS-1:0] sum;
            longint              diff;
            longint              q;
            pct_word_t           w;
            span = (window == 0) ? 1 : (window > WINDOW_MAX) ? WINDOW_MAX : window;
            leaving = '0;
            if (filled >= span) begin
                leaving = history[(head + WINDOW_MAX - span) % WINDOW_MAX];
            end
            sum = last_sum + x - leaving;
            history[head] = x;
            head = (head + 1) % WINDOW_MAX;
            if (filled < WINDOW_MAX) begin
                filled++;
            end
            w.moving_sum = sum;
            if (last_sum == 0) begin
                w.percent  = PCT_MAX;
                w.infinite = 1'b1;
            end else begin
                diff = longint'(sum) - longint'(last_sum);
                q = diff * longint'(SCALE_Q8) / longint'(last_sum);
                if (q > longint'(signed'(PCT_MAX))) begin
                    q = longint'(signed'(PCT_MAX));
                end
                if (q < longint'(signed'(PCT_MIN))) begin
                    q = longint'(signed'(PCT_MIN));
                end
                w.percent  = 32'(q);
                w.infinite = 1'b0;
            end
            last_sum = sum;
            awaited_figures = {awaited_figures, w};
        endfunction

        task compare_figures(logic [SUM_BITS-1:0] s, logic [PCT_BITS-1:0] p,
                             logic inf);
            pct_word_t w;
            if (awaited_figures.size() == 0) begin
                report($sformatf("result word with nothing expected: sum %0d", s));
                return;
            end
            w = awaited_figures.pop_front();
            if (s !== w.moving_sum) begin
                report($sformatf("moving_sum got %0d exp %0d", s, w.moving_sum));
            end
            if (p !== w.percent) begin
                report($sformatf("percent_q8 got %0d exp %0d (sum %0d)",
                                 $signed(p), $signed(w.percent), w.moving_sum));
            end
            if (inf !== w.infinite) begin
                report($sformatf("percent_infinite got %0b exp %0b (sum %0d)",
                                 inf, w.infinite, w.moving_sum));
            end
        endtask
    endclass

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [WIN_CFG_BITS-1:0] cfg_wr_data = '0;
    logic                    s_valid     = 1'b0;
    logic                    s_ready;
    logic [SAMPLE_W-1:0]     s_sample    = '0;
    logic                    m_valid;
    logic                    m_ready     = 1'b0;
    logic [SUM_BITS-1:0]     m_moving_sum;
    logic signed [PCT_BITS-1:0] m_percent_q8;
    logic                    m_percent_infinite;

    bit          calm_tail    = 1'b0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;

    window_sum_board board = new();

    moving_sum_percent_change dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample           (s_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_moving_sum       (m_moving_sum),
        .m_percent_q8       (m_percent_q8),
        .m_percent_infinite (m_percent_infinite)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                board.compare_figures(m_moving_sum, m_percent_q8, m_percent_infinite);
            end
            if (s_valid && s_ready) begin
                board.advance_window(s_sample);
            end
        end
    end

    initial begin : watchdog
        int unsigned idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : result_stalls
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm_tail && rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return SAMPLE_W'(SAMPLE_MAX);
            2: return SAMPLE_W'($urandom_range(0, 15));
            3: return SAMPLE_W'($urandom_range(SAMPLE_MAX - 15, SAMPLE_MAX));
            default: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high after acceptance
    task automatic send_sample(input logic [SAMPLE_W-1:0] x);
        if (!calm_tail && tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_sample = x;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic feed_samples(input int unsigned count, input sample_src_t src);
        tx_idle_pct  = $urandom_range(0, 2) * 25;
        rx_stall_pct = $urandom_range(0, 2) * 25;
        for (int unsigned i = 0; i < count; i++) begin
            if (src == SRC_PEAK_FIRST && i < 260) begin
                send_sample(SAMPLE_W'(SAMPLE_MAX));
            end else begin
                send_sample(rand_sample());
            end
        end
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (board.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_window(input int unsigned w);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = WIN_CFG_BITS'(w);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_window(w);
    endtask

    initial begin : stimulus
        logic [SAMPLE_W-1:0] opening [13] = '{0, 0, 65535, 1, 65535, 0, 0, 0, 0, 0, 0, 0, 5};
        logic [SAMPLE_W-1:0] narrow  [7]  = '{60000, 60000, 60000, 60000, 60000, 60000, 1};
        logic [SAMPLE_W-1:0] widened [2]  = '{0, 65535};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset window, zero previous sums, drop to zero and back
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        foreach (opening[i]) send_sample(opening[i]);
        // zero length acts as one
        set_window(0);
        foreach (narrow[i]) send_sample(narrow[i]);
        // widening mid-stream wraps the sum, percent saturates high
        set_window(7);
        foreach (widened[i]) send_sample(widened[i]);
        // oversized length clamps to the full line
        set_window(511);
        repeat (3) send_sample(SAMPLE_W'(SAMPLE_MAX));

        set_window(1);
        feed_samples($urandom_range(25, 50), SRC_MIXED);
        set_window(WINDOW_MAX);
        feed_samples(280, SRC_PEAK_FIRST);
        set_window(3);
        feed_samples($urandom_range(25, 50), SRC_MIXED);
        set_window(0);
        feed_samples($urandom_range(25, 50), SRC_MIXED);
        set_window(WINDOW_MAX + 1);
        feed_samples($urandom_range(25, 50), SRC_MIXED);
        set_window($urandom_range(2, WINDOW_MAX - 1));
        feed_samples($urandom_range(25, 50), SRC_MIXED);
        set_window(511);
        feed_samples($urandom_range(25, 50), SRC_MIXED);

        calm_tail = 1'b1;
        set_window($urandom_range(1, 511));
        feed_samples(40, SRC_MIXED);

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/msp_pkg.sv
rtl/core/msp_div.sv
rtl/core/moving_sum_percent_change.sv
rtl/core/msp_checker.sv
tb/moving_sum_percent_change_tb.sv
